// ===== sv/lpm_pkg.sv =====
package lpm_pkg;

    // Store size
    localparam int MAX_TOKENS_DEF = 64;

    // Pattern bytes with a fixed meaning
    localparam logic [7:0] CH_RUN    = 8'h25;
    localparam logic [7:0] CH_ONE    = 8'h5F;
    localparam logic [7:0] ESC_RESET = 8'h5C;

    // Token kinds
    localparam logic [1:0] KIND_LIT = 2'd0;
    localparam logic [1:0] KIND_ONE = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;

    // Commands
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;
    localparam logic [1:0] CMD_END     = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_LONE_ESC = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } token_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        logic       matched;
        logic [1:0] status;
    } out_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic       text_step;
        logic       restart;
        token_t     wr_token;
        logic [7:0] text_byte;
    } cell_ctrl_t;

endpackage

// ===== sv/lpm_cell.sv =====
// One pattern position: holds token i and the active bit of position i.
module lpm_cell #(
    parameter logic RESET_ACTIVE = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lpm_pkg::cell_ctrl_t ctrl,
    input  logic               wr_en,
    input  logic               valid,
    input  logic               restart_val,
    input  logic               fwd_in,
    input  logic               pre_in,
    input  logic               run_in,
    output logic               fwd_out,
    output logic               pre_out,
    output logic               run_out,
    output logic               active
);

    lpm_pkg::token_t tok_reg;
    logic            active_reg;
    logic            active_next;
    logic            is_run;
    logic            pre;

    // Token storage, written once per pattern load
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tok_reg <= ctrl.wr_token;
        end
    end

    assign is_run = valid && (tok_reg.kind == lpm_pkg::KIND_RUN);

    // Advance to the next position on a single-byte match
    assign fwd_out = active_reg && valid && (tok_reg.kind != lpm_pkg::KIND_RUN) &&
                     ((tok_reg.kind == lpm_pkg::KIND_ONE) ||
                      (tok_reg.value == ctrl.text_byte));

    // Arrival from the left or staying on an any-run
    assign pre     = fwd_in || (active_reg && is_run);
    assign pre_out = pre;
    assign run_out = is_run;

    // Closure: an any-run on the left may match nothing (runs never adjoin)
    always_comb
    begin
        if (ctrl.restart)
        begin
            active_next = restart_val;
        end
        else if (ctrl.text_step)
        begin
            active_next = pre || (pre_in && run_in);
        end
        else
        begin
            active_next = active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= RESET_ACTIVE;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

// ===== sv/like_pattern_matcher.sv =====
// SQL LIKE matcher with escape. Every command is one transaction and the block takes one per
// cycle, back to back: the pattern is compiled into a chain of MAX_TOKENS cells, each holding
// one token and one active position, and a text byte updates all positions at once
// through neighbor-to-neighbor links along the chain. Clear, pattern and text commands give no
// result; each end-of-text command gives one result (matched, status) in the next cycle through
// an output register, and input stalls only while that register is full and not taken.
// Status reports a pattern that overflowed the token store or ended in a lone escape; both
// force matched to 0. After each end of text the next text is matched against the same
// pattern. Loading a pattern byte or clearing restarts text matching.
module like_pattern_matcher #(
    parameter int MAX_TOKENS = lpm_pkg::MAX_TOKENS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [7:0]    cfg_wr_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  lpm_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output lpm_pkg::out_t out_data
);

    localparam int CW = $clog2(MAX_TOKENS + 1);

    logic [7:0]          esc_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                pend_reg, pend_next;
    logic                ovf_reg, ovf_next;
    logic                last_run_reg, last_run_next;
    logic                first_run_reg, first_run_next;
    logic                end_active_reg, end_active_next;
    logic                out_valid_reg, out_valid_next;
    lpm_pkg::out_t       out_data_reg, out_data_next;

    logic                accept;
    logic                do_append;
    logic [1:0]          app_kind;
    logic                esc_on;
    logic                hit;
    lpm_pkg::cell_ctrl_t ctrl;

    logic [MAX_TOKENS-1:0] fwd, pre, run, act;
    logic [MAX_TOKENS:0]   act_all;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign esc_on   = (esc_reg != lpm_pkg::CH_RUN) && (esc_reg != lpm_pkg::CH_ONE);

    // Escape register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= lpm_pkg::ESC_RESET;
        end
        else if (cfg_wr_en)
        begin
            esc_reg <= cfg_wr_data;
        end
    end

    // Pattern compiler: classify a pattern byte
    always_comb
    begin
        do_append = 1'b0;
        app_kind  = lpm_pkg::KIND_LIT;
        pend_next = pend_reg;
        if (accept && (in_data.command == lpm_pkg::CMD_PATTERN))
        begin
            if (pend_reg)
            begin
                pend_next = 1'b0;
                do_append = 1'b1;
            end
            else if (esc_on && (in_data.byte_value == esc_reg))
            begin
                pend_next = 1'b1;
            end
            else if (in_data.byte_value == lpm_pkg::CH_RUN)
            begin
                do_append = !last_run_reg;
                app_kind  = lpm_pkg::KIND_RUN;
            end
            else if (in_data.byte_value == lpm_pkg::CH_ONE)
            begin
                do_append = 1'b1;
                app_kind  = lpm_pkg::KIND_ONE;
            end
            else
            begin
                do_append = 1'b1;
            end
        end
        else if (accept && (in_data.command == lpm_pkg::CMD_CLEAR))
        begin
            pend_next = 1'b0;
        end
    end

    // Token store bookkeeping
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_run_next  = last_run_reg;
        first_run_next = first_run_reg;
        if (accept && (in_data.command == lpm_pkg::CMD_CLEAR))
        begin
            count_next     = '0;
            ovf_next       = 1'b0;
            last_run_next  = 1'b0;
            first_run_next = 1'b0;
        end
        else if (do_append)
        begin
            if (count_reg >= CW'(MAX_TOKENS))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next    = CW'(count_reg + 1'b1);
                last_run_next = (app_kind == lpm_pkg::KIND_RUN);
                if (count_reg == '0)
                begin
                    first_run_next = (app_kind == lpm_pkg::KIND_RUN);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            last_run_reg  <= 1'b0;
            first_run_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            ovf_reg       <= ovf_next;
            last_run_reg  <= last_run_next;
            first_run_reg <= first_run_next;
        end
    end

    // Broadcast control for the chain
    always_comb
    begin
        ctrl.text_step      = accept && (in_data.command == lpm_pkg::CMD_TEXT);
        ctrl.restart        = accept && (in_data.command != lpm_pkg::CMD_TEXT);
        ctrl.wr_token.kind  = app_kind;
        ctrl.wr_token.value = (app_kind == lpm_pkg::KIND_LIT) ? in_data.byte_value : 8'h00;
        ctrl.text_byte      = in_data.byte_value;
    end

    // Chain of position cells
    for (genvar i = 0; i < MAX_TOKENS; i++)
    begin : g_cell
        logic cell_fwd_in, cell_pre_in, cell_run_in, cell_rv, cell_wr;

        if (i == 0)
        begin : g_first
            assign cell_fwd_in = 1'b0;
            assign cell_pre_in = 1'b0;
            assign cell_run_in = 1'b0;
            assign cell_rv     = 1'b1;
        end
        else
        begin : g_rest
            assign cell_fwd_in = fwd[i-1];
            assign cell_pre_in = pre[i-1];
            assign cell_run_in = run[i-1];
            assign cell_rv     = (i == 1) ? first_run_next : 1'b0;
        end

        assign cell_wr = do_append && (count_reg == CW'(i));

        lpm_cell #(
            .RESET_ACTIVE((i == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .wr_en       (cell_wr),
            .valid       (count_reg > CW'(i)),
            .restart_val (cell_rv),
            .fwd_in      (cell_fwd_in),
            .pre_in      (cell_pre_in),
            .run_in      (cell_run_in),
            .fwd_out     (fwd[i]),
            .pre_out     (pre[i]),
            .run_out     (run[i]),
            .active      (act[i])
        );
    end

    // Final position past the last cell
    always_comb
    begin
        if (ctrl.restart)
        begin
            end_active_next = 1'b0;
        end
        else if (ctrl.text_step)
        begin
            end_active_next = fwd[MAX_TOKENS-1] || (pre[MAX_TOKENS-1] && run[MAX_TOKENS-1]);
        end
        else
        begin
            end_active_next = end_active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_active_reg <= 1'b0;
        end
        else
        begin
            end_active_reg <= end_active_next;
        end
    end

    assign act_all = {end_active_reg, act};
    assign hit     = act_all[count_reg];

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (accept && (in_data.command == lpm_pkg::CMD_END))
        begin
            out_valid_next = 1'b1;
            if (ovf_reg)
            begin
                out_data_next.status  = lpm_pkg::ST_OVERFLOW;
                out_data_next.matched = 1'b0;
            end
            else if (pend_reg)
            begin
                out_data_next.status  = lpm_pkg::ST_LONE_ESC;
                out_data_next.matched = 1'b0;
            end
            else
            begin
                out_data_next.status  = lpm_pkg::ST_OK;
                out_data_next.matched = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/sv/tb_like_pattern_matcher.sv =====
`timescale 1ns / 100ps

module tb_like_pattern_matcher;
    import lpm_pkg::*;

    localparam int STORE_DEPTH = MAX_TOKENS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int CHUNK_ITEMS = 200;

    // Clock and DUT ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    always #2 clk = ~clk;

    like_pattern_matcher #(
        .MAX_TOKENS(STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // Stimulus and scoreboard storage
    in_t pending_items[$];
    out_t pending_verdicts[$];
    int queued_total = 0;
    int items_seen = 0;
    int results_seen = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_done = 0;
    int hold_left = 0;
    int esc_writes = 0;
    logic in_took = 1'b0;

    // Matcher model state
    token_t pat_tok [STORE_DEPTH];
    int unsigned tok_total = 0;
    bit esc_wait = 1'b0;
    bit store_over = 1'b0;
    logic [STORE_DEPTH:0] live_pos = {{STORE_DEPTH{1'b0}}, 1'b1};
    logic [7:0] esc_byte = ESC_RESET;

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // Any-run tokens may match nothing, so they pass activity on to the next position
    function automatic logic [STORE_DEPTH:0] spread_runs(input logic [STORE_DEPTH:0] v);
        logic [STORE_DEPTH:0] r;
        r = v;
        for (int i = 0; i < tok_total; i++)
        begin
            if (r[i] && pat_tok[i].kind == KIND_RUN)
                r[i+1] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [STORE_DEPTH:0] start_positions();
        logic [STORE_DEPTH:0] v;
        v = '0;
        v[0] = 1'b1;
        return spread_runs(v);
    endfunction

    function automatic void add_token(input logic [1:0] kind, input logic [7:0] b);
        if (kind == KIND_RUN && tok_total > 0 && pat_tok[tok_total-1].kind == KIND_RUN)
            return;
        if (tok_total >= STORE_DEPTH)
        begin
            store_over = 1'b1;
            return;
        end
        pat_tok[tok_total].kind = kind;
        pat_tok[tok_total].value = b;
        tok_total++;
    endfunction

    function automatic void compile_byte(input logic [7:0] b);
        bit esc_on;
        esc_on = (esc_byte != CH_RUN) && (esc_byte != CH_ONE);
        if (esc_wait)
        begin
            esc_wait = 1'b0;
            add_token(KIND_LIT, b);
        end
        else if (esc_on && b == esc_byte)
            esc_wait = 1'b1;
        else if (b == CH_RUN)
            add_token(KIND_RUN, 8'h00);
        else if (b == CH_ONE)
            add_token(KIND_ONE, 8'h00);
        else
            add_token(KIND_LIT, b);
    endfunction

    function automatic logic [STORE_DEPTH:0] advance_text(input logic [7:0] b);
        logic [STORE_DEPTH:0] nxt;
        nxt = '0;
        for (int i = 0; i < tok_total; i++)
        begin
            if (live_pos[i])
            begin
                if (pat_tok[i].kind == KIND_RUN)
                    nxt[i] = 1'b1;
                else if (pat_tok[i].kind == KIND_ONE)
                    nxt[i+1] = 1'b1;
                else if (pat_tok[i].value == b)
                    nxt[i+1] = 1'b1;
            end
        end
        return spread_runs(nxt);
    endfunction

    // Update the model for one accepted transaction; end of text yields a verdict
    function automatic void step_matcher(input in_t it);
        out_t v;
        case (it.command)
            CMD_CLEAR:
            begin
                tok_total = 0;
                esc_wait = 1'b0;
                store_over = 1'b0;
                live_pos = start_positions();
            end
            CMD_PATTERN:
            begin
                compile_byte(it.byte_value);
                live_pos = start_positions();
            end
            CMD_TEXT:
                live_pos = advance_text(it.byte_value);
            default:
            begin
                if (store_over)
                    v.status = ST_OVERFLOW;
                else if (esc_wait)
                    v.status = ST_LONE_ESC;
                else
                    v.status = ST_OK;
                v.matched = (v.status == ST_OK) && live_pos[tok_total];
                pending_verdicts.push_back(v);
                live_pos = start_positions();
            end
        endcase
    endfunction

    // Input side: present the next pending transaction, or hold/idle
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_took)
            ;
        else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            in_data <= pending_items.pop_front();
            in_valid <= 1'b1;
        end
        else
            in_valid <= 1'b0;
    end

    // Output side: random back-pressure plus long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_asked)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_asked;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: check results, predict from accepted transactions, watchdog
    always @(posedge clk)
    begin : monitor
        out_t want;
        cycle_count++;
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = pending_verdicts.pop_front();
                if (out_data.matched !== want.matched)
                    report_mismatch($sformatf("matched got %0b want %0b",
                        out_data.matched, want.matched));
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                        out_data.status, want.status));
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            step_matcher(in_data);
            items_seen++;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] b);
        in_t it;
        it.command = cmd;
        it.byte_value = b;
        pending_items.push_back(it);
        queued_total++;
    endtask

    // Mostly letters from a small alphabet so that matches happen often
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(9) < 7)
            return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || pending_verdicts.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_escape(input logic [7:0] v);
        cfg_wr_data = v;
        cfg_wr_en = 1'b1;
        esc_byte = v;
        esc_writes++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // One pattern followed by a few texts, mostly built to match
    task automatic queue_sequence();
        token_t plan[$];
        logic [7:0] txt[$];
        logic [7:0] b;
        token_t t;
        int n_tok;
        int r;
        bit esc_on;
        esc_on = (esc_byte != CH_RUN) && (esc_byte != CH_ONE);
        if ($urandom_range(99) < 85)
            push_item(CMD_CLEAR, 8'($urandom_range(255)));
        n_tok = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
        for (int i = 0; i < n_tok; i++)
        begin
            r = $urandom_range(9);
            if (r < 2)
            begin
                t.kind = KIND_RUN;
                t.value = 8'h00;
                push_item(CMD_PATTERN, CH_RUN);
                if ($urandom_range(3) == 0)
                    push_item(CMD_PATTERN, CH_RUN);
            end
            else if (r == 2)
            begin
                t.kind = KIND_ONE;
                t.value = 8'h00;
                push_item(CMD_PATTERN, CH_ONE);
            end
            else
            begin
                b = pick_byte();
                if (b == CH_RUN || b == CH_ONE || (esc_on && b == esc_byte))
                begin
                    if (esc_on)
                        push_item(CMD_PATTERN, esc_byte);
                    else
                        b = "a";
                end
                else if (esc_on && $urandom_range(9) == 0)
                    push_item(CMD_PATTERN, esc_byte);
                push_item(CMD_PATTERN, b);
                t.kind = KIND_LIT;
                t.value = b;
            end
            plan.push_back(t);
        end
        // dangling escape at the end of the pattern
        if (esc_on && $urandom_range(11) == 0)
            push_item(CMD_PATTERN, esc_byte);
        repeat ($urandom_range(1, 4))
        begin
            txt.delete();
            r = $urandom_range(99);
            if (r < 65)
            begin
                foreach (plan[i])
                begin
                    if (plan[i].kind == KIND_RUN)
                        repeat ($urandom_range(0, 3)) txt.push_back(pick_byte());
                    else if (plan[i].kind == KIND_ONE)
                        txt.push_back(8'($urandom_range(255)));
                    else
                        txt.push_back(plan[i].value);
                end
                if (r >= 45)
                begin
                    case ($urandom_range(2))
                        0: if (txt.size() > 0)
                               txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
                        1: if (txt.size() > 0)
                               void'(txt.pop_back());
                        default: txt.push_back(pick_byte());
                    endcase
                end
            end
            else
                repeat ($urandom_range(0, 8)) txt.push_back(pick_byte());
            foreach (txt[i])
            begin
                push_item(CMD_TEXT, txt[i]);
                // broken sequences: pattern edit or clear in the middle of a text
                if ($urandom_range(59) == 0)
                    push_item(CMD_PATTERN, pick_byte());
                else if ($urandom_range(119) == 0)
                    push_item(CMD_CLEAR, 8'($urandom_range(255)));
            end
            push_item(CMD_END, 8'($urandom_range(255)));
        end
    endtask

    // Short directed cases with the reset escape (backslash)
    task automatic queue_directed();
        push_item(CMD_END, 8'h00);                 // empty pattern, empty text
        push_item(CMD_TEXT, "a");
        push_item(CMD_END, 8'hFF);                 // empty pattern, non-empty text
        push_item(CMD_PATTERN, "a");
        push_item(CMD_PATTERN, CH_RUN);
        push_item(CMD_PATTERN, CH_RUN);            // merged runs
        push_item(CMD_TEXT, "a");
        push_item(CMD_TEXT, "x");
        push_item(CMD_TEXT, 8'hFF);
        push_item(CMD_END, 8'h00);
        push_item(CMD_END, 8'h00);                 // restarted after end of text
        push_item(CMD_PATTERN, ESC_RESET);
        push_item(CMD_END, 8'h00);                 // lone escape
        push_item(CMD_PATTERN, CH_RUN);            // escaped run char is a literal
        push_item(CMD_TEXT, "a");
        push_item(CMD_TEXT, CH_RUN);
        push_item(CMD_END, 8'h00);
        push_item(CMD_CLEAR, 8'hFF);
        push_item(CMD_PATTERN, CH_ONE);
        push_item(CMD_PATTERN, ESC_RESET);
        push_item(CMD_PATTERN, ESC_RESET);         // escaped escape
        push_item(CMD_TEXT, 8'hFF);
        push_item(CMD_PATTERN, CH_RUN);            // pattern byte mid-text
        push_item(CMD_TEXT, 8'h00);
        push_item(CMD_TEXT, ESC_RESET);
        push_item(CMD_END, 8'h00);
    endtask

    // Token store at capacity, merge into a final run, overflow and its priority
    task automatic queue_store_full();
        push_item(CMD_CLEAR, 8'h00);
        repeat (STORE_DEPTH - 1) push_item(CMD_PATTERN, "a");
        push_item(CMD_PATTERN, CH_RUN);
        push_item(CMD_PATTERN, CH_RUN);
        repeat (STORE_DEPTH - 1) push_item(CMD_TEXT, "a");
        push_item(CMD_TEXT, "q");
        push_item(CMD_END, 8'h00);
        push_item(CMD_PATTERN, "b");
        push_item(CMD_END, 8'h00);
        push_item(CMD_PATTERN, ESC_RESET);
        push_item(CMD_END, 8'h00);
        push_item(CMD_CLEAR, 8'h00);
        repeat (STORE_DEPTH) push_item(CMD_PATTERN, "c");
        repeat (STORE_DEPTH) push_item(CMD_TEXT, "c");
        push_item(CMD_END, 8'h00);
        push_item(CMD_CLEAR, 8'h00);
        push_item(CMD_END, 8'h00);
    endtask

    initial
    begin : stim
        logic [7:0] esc_plan [8];
        int start;
        esc_plan = '{8'h00, 8'hFF, CH_RUN, CH_ONE, ESC_RESET, 8'h00, 8'h00, "a"};
        esc_plan[5] = 8'($urandom_range(255));
        esc_plan[6] = 8'($urandom_range(255));
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 69;
        queue_directed();
        wait_idle();
        queue_store_full();
        wait_idle();

        // Random chunks over several escape settings and idling mixes
        for (int chunk = 0; chunk < 8; chunk++)
        begin
            set_escape(esc_plan[chunk]);
            if (chunk < 3)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 69;
            end
            else if (chunk < 6)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (chunk == 1 || chunk == 6)
                hold_asked++;
            start = queued_total;
            while (queued_total - start < CHUNK_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(3, 10))
                        push_item(2'($urandom_range(3)), 8'($urandom_range(255)));
                else
                    queue_sequence();
            end
            wait_idle();
        end

        repeat (10) @(negedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                pending_verdicts.size()));
        $display("Covered %0d input transactions and %0d results over %0d escape settings,",
            items_seen, results_seen, esc_writes + 1);
        $display("with store overflow, lone escapes, mid-text edits, hold-off and idle mixes.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
